### rtl/bsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_pkg - bitmap slot allocator shared definitions
// Sizes, request and status codes, and the structs between the modules.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int MAX_SLOTS     = 1024;
    localparam int MAP_WORD_BITS = 32;
    localparam int MAP_WORDS     = (MAX_SLOTS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

    localparam int SLOT_W  = $clog2(MAX_SLOTS);
    localparam int BIT_W   = $clog2(MAP_WORD_BITS);
    localparam int WADDR_W = $clog2(MAP_WORDS);
    localparam int CNT_W   = $clog2(MAX_SLOTS + 1);

    localparam int ES_W       = 16;
    localparam int SC_W       = 11;
    localparam int OFF_W      = 26;
    localparam int MODE_W     = 2;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_IDX_W  = 10;
    localparam int OUT_USED_W = 11;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = MODE_W;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = STAT_W;

    localparam int OUT_OFF_LSB  = OUT_IDX_W;
    localparam int OUT_USED_LSB = OUT_IDX_W + OFF_W;

    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_REJECT    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_ALLOC = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT   = 2'd1;

    typedef logic [MAP_WORD_BITS-1:0] map_word_t;
    typedef logic [WADDR_W-1:0]       waddr_t;

    typedef struct packed {
        logic      en;
        waddr_t    addr;
        map_word_t data;
    } map_wr_t;

    typedef struct packed {
        logic             start;
        logic [OFF_W-1:0] dividend;
        logic [ES_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [OFF_W-1:0] quotient;
        logic [ES_W-1:0]  remainder;
    } div_rsp_t;

    // lowest set bit of a map word
    function automatic logic [BIT_W-1:0] first_set(input map_word_t v);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
            if (v[j]) begin
                pos = BIT_W'(j);
            end
        end
        return pos;
    endfunction

endpackage
`default_nettype wire

### rtl/bsa_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_divider - shared restoring divider
// One quotient bit per cycle; done pulses with quotient and remainder.
// ----------------------------------------------------------------------------
module bsa_divider import bsa_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int DCNT_W = $clog2(OFF_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [OFF_W-1:0]  quo_reg, quo_next;
    logic [ES_W-1:0]   rem_reg, rem_next;
    logic [ES_W-1:0]   dsr_reg, dsr_next;
    logic [ES_W:0]     shifted;
    logic [ES_W:0]     trial;

    assign shifted = {rem_reg, quo_reg[OFF_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = DCNT_W'(OFF_W - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end else if (busy_reg) begin
            if (!trial[ES_W]) begin
                rem_next = trial[ES_W-1:0];
                quo_next = {quo_reg[OFF_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[ES_W-1:0];
                quo_next = {quo_reg[OFF_W-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
`default_nettype wire

### rtl/bsa_map_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_map_ram - used-bitmap word store
// One write and one registered read per cycle; per-word valid flags make
// a cleared word read as all free.
// ----------------------------------------------------------------------------
module bsa_map_ram import bsa_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    clear,
    input  wire waddr_t  rd_addr,
    output map_word_t    rd_data,
    input  wire map_wr_t wr
);

    map_word_t             mem [MAP_WORDS];
    logic [MAP_WORDS-1:0]  vld_reg;
    map_word_t             rd_data_reg;
    logic                  rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            vld_reg <= '0;
        end else if (wr.en) begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
        rd_vld_reg  <= vld_reg[rd_addr];
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire

### rtl/bitmap_slot_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_top - fixed-size slot allocator, next-fit bitmap
// Sequencer over the bitmap word store and one shared divider.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  s_       in         s_tvalid/s_tready  tuser mode, tdata release_offset
//  m_       out        m_tvalid/m_tready  tuser status, tdata index/offset/used
//  cfg_     in         cfg_valid/ready    cfg_index, cfg_wdata
//
//  Allocate: k map words scanned (1 .. words+1, 33 at most), after a
//    divider pass when the cursor is at or above the capacity.
//  Release: the 26-step serial divider, then a map check unless rejected.
//  Clear and unused mode: no scan. One item at a time; s_tready and cfg_ready
//  are high only when idle, a pending config write going first. A finished
//  result waits for a free output register. Sync reset clears the map at once.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_top import bsa_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [25:0] release_offset
    input  wire logic [S_TUSER_W-1:0]  s_tuser,   // [1:0] mode
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [9:0] slot_index,
                                                  // [35:10] byte_offset,
                                                  // [46:36] used_slots
    output logic [M_TUSER_W-1:0]       m_tuser,   // [1:0] status
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;
    localparam logic [2:0] S_ISSUE  = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_RISSUE = 3'd4;
    localparam logic [2:0] S_RCHK   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [ES_W-1:0]      es_reg, es_next;
    logic [SC_W-1:0]      sc_reg, sc_next;
    logic [SLOT_W-1:0]    cursor_reg, cursor_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [SLOT_W-1:0]    start_reg, start_next;
    waddr_t               wp_reg, wp_next;
    logic                 wrapped_reg, wrapped_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [STAT_W-1:0]    stat_reg, stat_next;
    logic                 grant_reg, grant_next;

    logic [CNT_W-1:0]     cap_eff;
    logic [ES_W-1:0]      es_eff;
    logic [SLOT_W-1:0]    last_slot;
    waddr_t               last_word;
    logic [BIT_W-1:0]     last_bit;
    waddr_t               start_word;
    logic [BIT_W-1:0]     start_bit;
    waddr_t               scan_adv;
    map_word_t            scan_mask;
    map_word_t            cand;
    logic                 found;
    logic [BIT_W-1:0]     found_bit;
    logic [SLOT_W-1:0]    grant_slot;
    logic [CNT_W-1:0]     slot_inc;
    logic [BIT_W-1:0]     rel_bit;
    logic [OFF_W-1:0]     prod;
    logic                 accept;

    waddr_t               rd_addr;
    map_word_t            rd_data;
    map_wr_t              map_wr;
    logic                 map_clear;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    bsa_map_ram u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (map_clear),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (map_wr)
    );

    bsa_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // effective capacity and element size
    always_comb begin
        if (sc_reg == '0) begin
            cap_eff = CNT_W'(1);
        end else if (CNT_W'(sc_reg) > CNT_W'(MAX_SLOTS)) begin
            cap_eff = CNT_W'(MAX_SLOTS);
        end else begin
            cap_eff = CNT_W'(sc_reg);
        end
        es_eff = (es_reg == '0) ? ES_W'(1) : es_reg;
    end

    assign last_slot  = SLOT_W'(cap_eff - 1'b1);
    assign last_word  = WADDR_W'(last_slot >> BIT_W);
    assign last_bit   = last_slot[BIT_W-1:0];
    assign start_word = WADDR_W'(start_reg >> BIT_W);
    assign start_bit  = start_reg[BIT_W-1:0];
    assign scan_adv   = (wp_reg == last_word) ? '0 : wp_reg + 1'b1;

    // candidate bits of the word under scan
    always_comb begin
        for (int j = 0; j < MAP_WORD_BITS; j++) begin
            scan_mask[j] = (wp_reg != last_word) || (BIT_W'(j) <= last_bit);
            if (wp_reg == start_word) begin
                if (wrapped_reg) begin
                    scan_mask[j] = scan_mask[j] && (BIT_W'(j) < start_bit);
                end else begin
                    scan_mask[j] = scan_mask[j] && (BIT_W'(j) >= start_bit);
                end
            end
        end
    end

    assign cand       = ~rd_data & scan_mask;
    assign found      = |cand;
    assign found_bit  = first_set(cand);
    assign grant_slot = {wp_reg, found_bit};
    assign slot_inc   = CNT_W'(grant_slot) + 1'b1;
    assign rel_bit    = idx_reg[BIT_W-1:0];
    assign prod       = {{(OFF_W-SLOT_W){1'b0}}, idx_reg} * {{(OFF_W-ES_W){1'b0}}, es_eff};

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next    = state_reg;
        es_next       = es_reg;
        sc_next       = sc_reg;
        cursor_next   = cursor_reg;
        used_next     = used_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mode_next     = mode_reg;
        start_next    = start_reg;
        wp_next       = wp_reg;
        wrapped_next  = wrapped_reg;
        idx_next      = idx_reg;
        stat_next     = stat_reg;
        grant_next    = grant_reg;
        rd_addr       = '0;
        map_wr        = '0;
        map_clear     = 1'b0;
        div_req       = '0;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ELEMENT_SIZE: es_next = cfg_wdata[ES_W-1:0];
                CFG_SLOT_COUNT:   sc_next = cfg_wdata[SC_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    mode_next  = s_tuser;
                    idx_next   = '0;
                    grant_next = 1'b0;
                    stat_next  = STAT_DONE;
                    unique case (s_tuser)
                        MODE_ALLOC: begin
                            if (CNT_W'(cursor_reg) < cap_eff) begin
                                start_next = cursor_reg;
                                state_next = S_ISSUE;
                            end else begin
                                div_req.start    = 1'b1;
                                div_req.dividend = OFF_W'(cursor_reg);
                                div_req.divisor  = ES_W'(cap_eff);
                                state_next       = S_DIV;
                            end
                        end
                        MODE_RELEASE: begin
                            div_req.start    = 1'b1;
                            div_req.dividend = s_tdata[OFF_W-1:0];
                            div_req.divisor  = es_eff;
                            state_next       = S_DIV;
                        end
                        MODE_CLEAR: begin
                            map_clear   = 1'b1;
                            cursor_next = '0;
                            used_next   = '0;
                            state_next  = S_DONE;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (mode_reg == MODE_ALLOC) begin
                        start_next = SLOT_W'(div_rsp.remainder);
                        state_next = S_ISSUE;
                    end else if (div_rsp.remainder != '0 ||
                                 div_rsp.quotient >= OFF_W'(cap_eff)) begin
                        stat_next  = STAT_REJECT;
                        state_next = S_DONE;
                    end else begin
                        idx_next   = SLOT_W'(div_rsp.quotient);
                        state_next = S_RISSUE;
                    end
                end
            end
            S_ISSUE: begin
                rd_addr      = start_word;
                wp_next      = start_word;
                wrapped_next = 1'b0;
                state_next   = S_SCAN;
            end
            S_SCAN: begin
                rd_addr = scan_adv;
                if (found) begin
                    map_wr.en   = 1'b1;
                    map_wr.addr = wp_reg;
                    map_wr.data = rd_data | (map_word_t'(1) << found_bit);
                    used_next   = used_reg + 1'b1;
                    cursor_next = (slot_inc == cap_eff) ? '0 : SLOT_W'(slot_inc);
                    idx_next    = grant_slot;
                    grant_next  = 1'b1;
                    stat_next   = STAT_DONE;
                    state_next  = S_DONE;
                end else if (wrapped_reg && wp_reg == start_word) begin
                    stat_next  = STAT_FULL;
                    state_next = S_DONE;
                end else begin
                    wp_next      = scan_adv;
                    wrapped_next = wrapped_reg || (wp_reg == last_word);
                end
            end
            S_RISSUE: begin
                rd_addr    = WADDR_W'(idx_reg >> BIT_W);
                state_next = S_RCHK;
            end
            S_RCHK: begin
                if (rd_data[rel_bit]) begin
                    map_wr.en   = 1'b1;
                    map_wr.addr = WADDR_W'(idx_reg >> BIT_W);
                    map_wr.data = rd_data & ~(map_word_t'(1) << rel_bit);
                    if (used_reg != '0) begin
                        used_next = used_reg - 1'b1;
                    end
                    if (idx_reg < cursor_reg) begin
                        cursor_next = idx_reg;
                    end
                    stat_next = STAT_DONE;
                end else begin
                    stat_next = STAT_NOT_ALLOC;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = stat_reg;
                    m_tdata_next  = {{(M_TDATA_W-OUT_USED_W-OFF_W-OUT_IDX_W){1'b0}},
                                     OUT_USED_W'(used_reg),
                                     grant_reg ? prod : OFF_W'(0),
                                     OUT_IDX_W'(idx_reg)};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            es_reg       <= ES_W'(1);
            sc_reg       <= SC_W'(MAX_SLOTS);
            cursor_reg   <= '0;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            es_reg       <= es_next;
            sc_reg       <= sc_next;
            cursor_reg   <= cursor_next;
            used_reg     <= used_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        mode_reg    <= mode_next;
        start_reg   <= start_next;
        wp_reg      <= wp_next;
        wrapped_reg <= wrapped_next;
        idx_reg     <= idx_next;
        stat_reg    <= stat_next;
        grant_reg   <= grant_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

### rtl/bsa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_checker - port-level checks for the slot allocator
// Watches the item channels only; bound to the top level.
// ----------------------------------------------------------------------------
module bsa_checker import bsa_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser
);

    logic [OUT_IDX_W-1:0]  out_idx;
    logic [OFF_W-1:0]      out_off;
    logic [OUT_USED_W-1:0] out_used;

    assign out_idx  = m_tdata[OUT_IDX_W-1:0];
    assign out_off  = m_tdata[OUT_OFF_LSB +: OFF_W];
    assign out_used = m_tdata[OUT_USED_LSB +: OUT_USED_W];

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accept");

    // only a granted allocation carries an offset
    a_off_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STAT_DONE |-> out_off == '0)
        else $error("offset on a failed item");

    a_idx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_FULL || m_tuser == STAT_REJECT) |-> out_idx == '0)
        else $error("index on a full or rejected item");

    a_used_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_used <= OUT_USED_W'(MAX_SLOTS))
        else $error("used count above pool size");

endmodule

bind bitmap_slot_allocator_top bsa_checker u_bsa_checker (.*);
`default_nettype wire
